### sv/omr_pkg.sv
// Shared types and constants for the OSC message relay router.
// No dependencies.
`default_nettype none
package omr_pkg;

  typedef enum logic [2:0] {
    OUT_MALFORMED = 3'd0,
    OUT_UNMATCHED = 3'd1,
    OUT_RELAY     = 3'd2,
    OUT_ALL       = 3'd3,
    OUT_SYSTEM    = 3'd4
  } outcome_e;

  typedef enum logic {
    MODE_PACKET = 1'b0,
    MODE_TABLE  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] byte_value;
    logic       last_byte;
    logic [2:0] table_relay;
    logic [5:0] table_pos;
  } in_word_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [2:0]  relay_index;
    logic        relay_state;
    logic        system_reboot;
    logic [7:0]  type_tag;
    logic [31:0] value_word;
    logic        value_present;
    logic [5:0]  address_length;
  } out_word_t;

  // table write request toward the address memory
  typedef struct packed {
    logic       en;
    logic [2:0] relay;
    logic [7:0] row;
    logic [7:0] data;
  } tbl_wr_t;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_FLT   = 8'h66;

  localparam int unsigned AP_LEN       = 3;
  localparam int unsigned REBOOT_LEN   = 7;
  localparam int unsigned RELAYALL_LEN = 10;
  localparam int unsigned MIN_PACKET   = 8;

  localparam logic [7:0] STR_AP [16] = '{
    8'h2F, 8'h61, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] STR_REBOOT [16] = '{
    8'h2F, 8'h72, 8'h65, 8'h62, 8'h6F, 8'h6F, 8'h74, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] STR_RELAYALL [16] = '{
    8'h2F, 8'h72, 8'h65, 8'h6C, 8'h61, 8'h79, 8'h2F, 8'h61,
    8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

endpackage
`default_nettype wire

### sv/omr_stream_if.sv
// Valid/ready stream interface carrying one word of type T.
// Depends on nothing; payload types come from omr_pkg.
`default_nettype none
interface omr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/osc_message_relay_router_top.sv
// OSC message relay router top level: streaming parser and routing decision.
// Depends on omr_pkg, omr_stream_if and omr_table.
//
// Takes one word per cycle, packet bytes and table writes alike, with no gaps
// between packets. A packet byte reads the address memory row for its position
// when accepted and is compared against all relays in stage 1; the result
// for the last byte is held in an output register, so input keeps flowing while
// a result waits, until the next packet's last byte reaches the compare stage.
// After reset the block clears the address memory and accepts no word during
// that pass.
`default_nettype none
module osc_message_relay_router_top #(
  parameter int unsigned RELAY_COUNT = 8,
  parameter int unsigned ADDR_MAX    = 64,
  parameter int unsigned PACKET_MAX  = 512
) (
  input wire           clk_i,
  input wire           rst_ni,
  omr_stream_if.sink   in_i,
  omr_stream_if.source out_o
);
  import omr_pkg::*;

  localparam int unsigned AW  = $clog2(ADDR_MAX);
  localparam int unsigned CW  = $clog2(PACKET_MAX + 1);
  localparam int unsigned XW  = CW + 3;
  localparam int unsigned RW  = RELAY_COUNT * 8;
  localparam int unsigned LIM = ADDR_MAX - 1;

  // stage 0: accept, count, table access
  logic          acc, stored0, busy;
  logic [CW-1:0] cnt_q, cnt_d;
  tbl_wr_t       wr;
  logic [RW-1:0] rd_data;
  logic          s1_go;

  // stage 1 registers
  logic          s1_valid_q, s1_valid_d;
  logic [7:0]    s1_byte_q;
  logic [CW-1:0] s1_pos_q;
  logic          s1_last_q, s1_stored_q;

  // parse state
  logic [RELAY_COUNT-1:0] rflag_q, rflag_d;
  logic [2:0]             lflag_q, lflag_d;
  logic                   nul_q, nul_d;
  logic [CW-1:0]          end_q, end_d;
  logic                   comma_q, comma_d;
  logic [7:0]             tag_q, tag_d;
  logic                   tseen_q, tseen_d;
  logic [31:0]            word_q, word_d;
  logic [2:0]             wcnt_q, wcnt_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, res;

  assign acc     = in_i.valid && in_i.ready;
  assign stored0 = 32'(cnt_q) < PACKET_MAX;
  assign s1_go   = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !busy && (!s1_valid_q || s1_go);

  always_comb begin
    wr.en    = acc && (in_i.data.mode == MODE_TABLE) &&
               (32'(in_i.data.table_relay) < RELAY_COUNT) &&
               (32'(in_i.data.table_pos) < ADDR_MAX);
    wr.relay = in_i.data.table_relay;
    wr.row   = 8'(in_i.data.table_pos);
    wr.data  = in_i.data.byte_value;
  end

  omr_table #(
    .RELAY_COUNT(RELAY_COUNT),
    .ADDR_MAX   (ADDR_MAX)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_en_i  (acc && (in_i.data.mode == MODE_PACKET)),
    .rd_addr_i(AW'(cnt_q)),
    .rd_data_o(rd_data),
    .busy_o   (busy)
  );

  always_comb begin
    cnt_d      = cnt_q;
    s1_valid_d = s1_valid_q;
    if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    if (acc && (in_i.data.mode == MODE_PACKET)) begin
      s1_valid_d = 1'b1;
      if (in_i.data.last_byte) begin
        cnt_d = '0;
      end else if (stored0) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (in_i.data.mode == MODE_PACKET)) begin
      s1_byte_q   <= in_i.data.byte_value;
      s1_pos_q    <= cnt_q;
      s1_last_q   <= in_i.data.last_byte;
      s1_stored_q <= stored0;
    end
  end

  // stage 1: per-byte parse update
  logic          addr_ph;
  logic [XW-1:0] px, tsx, len;
  logic [7:0]    cmpv;
  logic [3:0]    li;

  always_comb begin
    rflag_d = rflag_q;
    lflag_d = lflag_q;
    nul_d   = nul_q;
    end_d   = end_q;
    comma_d = comma_q;
    tag_d   = tag_q;
    tseen_d = tseen_q;
    word_d  = word_q;
    wcnt_d  = wcnt_q;
    px      = XW'(s1_pos_q);
    tsx     = (XW'(end_q) + XW'(4)) & ~XW'(3);
    addr_ph = s1_stored_q && !nul_q;
    li      = s1_pos_q[3:0];
    cmpv    = (32'(s1_pos_q) == LIM) ? 8'h00 : s1_byte_q;
    if (addr_ph) begin
      if (32'(s1_pos_q) < ADDR_MAX) begin
        for (int r = 0; r < RELAY_COUNT; r++) begin
          if (rd_data[r*8 +: 8] != cmpv) rflag_d[r] = 1'b0;
        end
      end
      if (32'(s1_pos_q) < LIM) begin
        if (32'(s1_pos_q) < AP_LEN && s1_byte_q != STR_AP[li]) lflag_d[0] = 1'b0;
        if (32'(s1_pos_q) < REBOOT_LEN && s1_byte_q != STR_REBOOT[li]) lflag_d[1] = 1'b0;
        if (32'(s1_pos_q) < RELAYALL_LEN && s1_byte_q != STR_RELAYALL[li]) begin
          lflag_d[2] = 1'b0;
        end
      end
      if (s1_byte_q == 8'h00) begin
        nul_d = 1'b1;
        end_d = s1_pos_q;
      end
    end
    if (s1_stored_q && nul_q) begin
      if (px == tsx) comma_d = (s1_byte_q == CH_COMMA);
      if (px == tsx + XW'(1)) begin
        tag_d   = s1_byte_q;
        tseen_d = 1'b1;
      end
      if (px >= tsx + XW'(4) && px < tsx + XW'(8)) begin
        word_d = {word_q[23:0], s1_byte_q};
        wcnt_d = wcnt_q + 3'd1;
      end
    end
  end

  // routing decision on the last byte
  logic          isif, present, ok, val, sys, reboot, all, hit;
  logic [AW-1:0] alen;
  logic [7:0]    tag;
  logic [2:0]    ridx;

  always_comb begin
    len     = s1_stored_q ? px + XW'(1) : px;
    alen    = (32'(end_q) < LIM) ? AW'(end_q) : AW'(LIM);
    tag     = tseen_d ? tag_d : 8'h00;
    isif    = (tag == CH_I) || (tag == CH_FLT);
    present = isif && (wcnt_d == 3'd4);
    ok      = present || (tag == CH_T) || (tag == CH_F);
    val     = isif ? (word_d != 32'd0) : (tag == CH_T);
    reboot  = lflag_q[1] && (32'(alen) == REBOOT_LEN);
    sys     = (lflag_q[0] && (32'(alen) >= AP_LEN)) || reboot;
    all     = lflag_q[2] && (32'(alen) == RELAYALL_LEN);
    hit     = 1'b0;
    ridx    = 3'd0;
    for (int r = RELAY_COUNT - 1; r >= 0; r--) begin
      if (rflag_q[r]) begin
        hit  = 1'b1;
        ridx = 3'(r);
      end
    end
    res = '0;
    if (32'(len) >= MIN_PACKET && comma_d) begin
      res.outcome        = OUT_UNMATCHED;
      res.type_tag       = tag;
      res.value_word     = present ? word_d : 32'd0;
      res.value_present  = present;
      res.address_length = 6'(alen);
      if (ok) begin
        priority if (sys) begin
          res.outcome       = OUT_SYSTEM;
          res.relay_state   = val;
          res.system_reboot = reboot;
        end else if (all) begin
          res.outcome     = OUT_ALL;
          res.relay_state = val;
        end else if (hit) begin
          res.outcome     = OUT_RELAY;
          res.relay_index = ridx;
          res.relay_state = val;
        end else begin
          res.outcome = OUT_UNMATCHED;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rflag_q <= '1;
      lflag_q <= '1;
      nul_q   <= 1'b0;
      end_q   <= '0;
      comma_q <= 1'b0;
      tag_q   <= '0;
      tseen_q <= 1'b0;
      word_q  <= '0;
      wcnt_q  <= '0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        rflag_q <= '1;
        lflag_q <= '1;
        nul_q   <= 1'b0;
        end_q   <= '0;
        comma_q <= 1'b0;
        tag_q   <= '0;
        tseen_q <= 1'b0;
        word_q  <= '0;
        wcnt_q  <= '0;
      end else begin
        rflag_q <= rflag_d;
        lflag_q <= lflag_d;
        nul_q   <= nul_d;
        end_q   <= end_d;
        comma_q <= comma_d;
        tag_q   <= tag_d;
        tseen_q <= tseen_d;
        word_q  <= word_d;
        wcnt_q  <= wcnt_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (s1_go && s1_last_q) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) out_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

### sv/omr_table.sv
// Relay address memory: one row per character position, one byte lane per relay.
// Clears itself after reset. Depends on omr_pkg.
`default_nettype none
module omr_table #(
  parameter int unsigned RELAY_COUNT = 8,
  parameter int unsigned ADDR_MAX    = 64
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  omr_pkg::tbl_wr_t               wr_i,
  input  wire                                  rd_en_i,
  input  wire  [$clog2(ADDR_MAX)-1:0]          rd_addr_i,
  output logic [RELAY_COUNT*8-1:0]             rd_data_o,
  output logic                                 busy_o
);
  import omr_pkg::*;

  localparam int unsigned AW = $clog2(ADDR_MAX);
  localparam int unsigned RW = RELAY_COUNT * 8;

  logic [RW-1:0] mem [ADDR_MAX];
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_row_q, clr_row_d;

  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      clr_row_d = clr_row_q + AW'(1);
      if (32'(clr_row_q) == ADDR_MAX - 1) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_row_q] <= '0;
    end else if (wr_i.en) begin
      for (int l = 0; l < RELAY_COUNT; l++) begin
        if (32'(wr_i.relay) == l) begin
          mem[AW'(wr_i.row)][l*8 +: 8] <= wr_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign busy_o = clr_q;

endmodule
`default_nettype wire

### sv/omr_checker.sv
// Port-level checks for the OSC message relay router, bound to the top level.
// Depends on omr_pkg.
`default_nettype none
module omr_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_i,
  input wire                 out_ready_i,
  input wire omr_pkg::out_word_t out_data_i
);
  import omr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.outcome == OUT_MALFORMED ||
                     out_data_i.outcome == OUT_UNMATCHED ||
                     out_data_i.outcome == OUT_RELAY ||
                     out_data_i.outcome == OUT_ALL ||
                     out_data_i.outcome == OUT_SYSTEM))
    else $error("outcome out of range");

  a_malformed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.outcome == OUT_MALFORMED |->
      out_data_i.type_tag == 8'h00 && out_data_i.value_word == 32'd0 &&
      !out_data_i.value_present && out_data_i.address_length == 6'd0 &&
      !out_data_i.relay_state)
    else $error("malformed result carries data");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.relay_index != 3'd0 |-> out_data_i.outcome == OUT_RELAY)
    else $error("relay index without relay outcome");

  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.value_present |->
      (out_data_i.type_tag == CH_I || out_data_i.type_tag == CH_FLT))
    else $error("argument reported for non-numeric tag");

endmodule

bind osc_message_relay_router_top omr_checker u_omr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
`default_nettype wire
